// ----- hw/rtl/pedal_rpm_tachometer_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef PEDAL_RPM_TACHOMETER_CORE_DEFINES_SVH
`define PEDAL_RPM_TACHOMETER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prt_pkg.sv -----
package prt_pkg;

  localparam int TS_W     = 32;
  localparam int RPM_W    = 16;
  localparam int DEB_W    = 20;
  localparam int POLE_W   = 7;
  localparam int ALPHA_W  = 8;
  localparam int STOP_W   = 8;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;

  // divisor = period * poles
  localparam int DVS_W    = TS_W + POLE_W;
  // rpm scale in Q4: 60e6 us/min * 16
  localparam int DVD_W    = 30;
  localparam logic [DVD_W-1:0] RPM_SCALE_Q4 = 30'd960000000;
  localparam int CNT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM  = 3'd4;

  localparam logic [0:0] FUNC_EDGE = 1'b0;
  localparam logic [0:0] FUNC_TICK = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RPM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/prt_if.sv -----
interface prt_in_if
  import prt_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [0:0]      func;
  logic [TS_W-1:0] timestamp_us;

  modport source (output valid, output func, output timestamp_us, input ready);
  modport sink   (input valid, input func, input timestamp_us, output ready);
endinterface

interface prt_out_if
  import prt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RPM_W-1:0] rpm_filtered;
  logic [RPM_W-1:0] rpm_raw;
  logic             stop_reset;

  modport source (output valid, output rpm_filtered, output rpm_raw, output stop_reset,
                  input ready);
  modport sink   (input valid, input rpm_filtered, input rpm_raw, input stop_reset,
                  output ready);
endinterface

// ----- hw/rtl/pedal_rpm_tachometer_core.sv -----
// Path: an edge item goes from accept straight to S_DONE; a tick without rpm update passes
// S_FIN and S_DONE; a tick with rpm update passes S_MUL, S_DIV (the 30-step bit-serial
// divider), S_BLD1, S_BLD2, S_FIN and S_DONE. Throughput: one item at a time; next item
// accepted once the current one reaches the output register, which waits on a stalled output.
// Reset (synchronous, active low): state cleared, registers to defaults, output empty.
module pedal_rpm_tachometer_core
  import prt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  prt_in_if.sink               in_s,
  prt_out_if.source            out_s,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_BLD1 = 7'b0001000,
    S_BLD2 = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DEB_W-1:0]   debounce_r;
  logic [POLE_W-1:0]  poles_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [STOP_W-1:0]  stop_lim_r;
  logic [RPM_W-1:0]   max_rpm_r;

  logic [TS_W-1:0]    last_ts_r, last_ts_nxt;
  logic [TS_W-1:0]    period_r, period_nxt;
  logic [STOP_W-1:0]  idle_r, idle_nxt;
  logic [RPM_W-1:0]   avg_r, avg_nxt;
  logic [RPM_W-1:0]   latest_r, latest_nxt;
  logic               stop_r, stop_nxt;
  logic [RPM_W-1:0]   raw_r, raw_nxt;
  logic [RPM_W+ALPHA_W-1:0] prod_r, prod_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [RPM_W-1:0]   ofilt_r, oraw_r;
  logic               ostop_r;
  logic               load_out;

  logic               in_acc;
  logic [ALPHA_W:0]   wnew;
  logic [RPM_W+ALPHA_W:0] blend;
  logic               stopping;
  logic [RPM_W-1:0]   avg_z;

  div_req_t div_req;
  div_rsp_t div_rsp;

  prt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_s.ready = (state_r == S_IDLE);
  assign in_acc     = in_s.valid && in_s.ready;
  assign load_out   = (state_r == S_DONE) && (!ovalid_r || out_s.ready);

  assign div_req.start   = (state_r == S_MUL);
  assign div_req.divisor = DVS_W'(period_r) * DVS_W'(poles_r);

  assign wnew     = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_r};
  assign blend    = {1'b0, prod_r} +
                    (RPM_W+ALPHA_W+1)'(raw_r) * (RPM_W+ALPHA_W+1)'(wnew);
  assign stopping = (idle_r > stop_lim_r);
  assign avg_z    = stopping ? '0 : avg_r;

  always_comb begin
    state_nxt   = state_r;
    last_ts_nxt = last_ts_r;
    period_nxt  = period_r;
    idle_nxt    = idle_r;
    avg_nxt     = avg_r;
    latest_nxt  = latest_r;
    stop_nxt    = stop_r;
    raw_nxt     = raw_r;
    prod_nxt    = prod_r;
    ovalid_nxt  = ovalid_r;
    if (ovalid_r && out_s.ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          stop_nxt = 1'b0;
          if (in_s.func == FUNC_EDGE) begin
            if (in_s.timestamp_us > last_ts_r) period_nxt = in_s.timestamp_us - last_ts_r;
            last_ts_nxt = in_s.timestamp_us;
            idle_nxt    = '0;
            state_nxt   = S_DONE;
          end else if (period_r > TS_W'(debounce_r)) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          raw_nxt   = div_rsp.quot;
          state_nxt = S_BLD1;
        end
      end
      S_BLD1: begin
        prod_nxt  = (RPM_W+ALPHA_W)'(avg_r) * (RPM_W+ALPHA_W)'(alpha_r);
        state_nxt = S_BLD2;
      end
      S_BLD2: begin
        latest_nxt = raw_r;
        avg_nxt    = blend[RPM_W+ALPHA_W-1:ALPHA_W];
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (idle_r != {STOP_W{1'b1}}) idle_nxt = idle_r + 1'b1;
        stop_nxt  = stopping;
        avg_nxt   = (avg_z > max_rpm_r) ? max_rpm_r : avg_z;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ovalid_r   <= 1'b0;
      debounce_r <= DEB_W'(20000);
      poles_r    <= POLE_W'(12);
      alpha_r    <= ALPHA_W'(192);
      stop_lim_r <= STOP_W'(50);
      max_rpm_r  <= RPM_W'(2400);
      last_ts_r  <= '0;
      period_r   <= '0;
      idle_r     <= '0;
      avg_r      <= '0;
      latest_r   <= '0;
      stop_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      last_ts_r <= last_ts_nxt;
      period_r  <= period_nxt;
      idle_r    <= idle_nxt;
      avg_r     <= avg_nxt;
      latest_r  <= latest_nxt;
      stop_r    <= stop_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_r <= cfg_data[DEB_W-1:0];
          CFG_POLES:    poles_r    <= cfg_data[POLE_W-1:0];
          CFG_ALPHA:    alpha_r    <= cfg_data[ALPHA_W-1:0];
          CFG_STOP:     stop_lim_r <= cfg_data[STOP_W-1:0];
          CFG_MAX_RPM:  max_rpm_r  <= cfg_data[RPM_W-1:0];
          default: ;
        endcase
      end
    end
    raw_r  <= raw_nxt;
    prod_r <= prod_nxt;
    if (load_out) begin
      ofilt_r <= avg_r;
      oraw_r  <= latest_r;
      ostop_r <= stop_r;
    end
  end

  assign out_s.valid        = ovalid_r;
  assign out_s.rpm_filtered = ofilt_r;
  assign out_s.rpm_raw      = oraw_r;
  assign out_s.stop_reset   = ostop_r;

endmodule

// ----- hw/rtl/prt_div.sv -----
// Restoring divider: fixed dividend RPM_SCALE_Q4, one quotient bit per cycle.
module prt_div
  import prt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             zero_r, zero_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      dvd_nxt  = RPM_SCALE_Q4;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
      zero_nxt = (req.divisor == '0);
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
  end

  assign rsp.done = done_r;
  // zero divisor or quotient above 16 bits saturates
  assign rsp.quot = (zero_r || (|quo_r[DVD_W-1:RPM_W])) ? {RPM_W{1'b1}} : quo_r[RPM_W-1:0];

endmodule

// ----- hw/rtl/prt_checker.sv -----
`include "pedal_rpm_tachometer_core_defines.svh"

module prt_checker
  import prt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RPM_W-1:0] out_rpm_filtered,
  input logic             out_stop_reset
);

  // one item in flight: ready drops right after an accept
  `PRT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted while busy")

  // a stop always leaves the filter at zero
  `PRT_ASSERT_NOW(a_stop_zero, out_valid && out_stop_reset, out_rpm_filtered == '0, "stop with nonzero rpm")

  `PRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind pedal_rpm_tachometer_core prt_checker u_prt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .out_valid        (out_s.valid),
  .out_ready        (out_s.ready),
  .out_rpm_filtered (out_s.rpm_filtered),
  .out_stop_reset   (out_s.stop_reset)
);

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [RPM_W-1:0] filt;
    logic [RPM_W-1:0] raw;
    logic             stop;
  } rpm_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [0:0]           func;
    logic [TS_W-1:0]      ts;
    bit                   known;
    rpm_result_t          want;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_QUARTER, RX_CHOKE} rx_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  prt_in_if  in_ch();
  prt_out_if out_ch();

  pedal_rpm_tachometer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and register copies
  logic [DEB_W-1:0]   c_debounce;
  logic [POLE_W-1:0]  c_poles;
  logic [ALPHA_W-1:0] c_alpha;
  logic [STOP_W-1:0]  c_stop;
  logic [RPM_W-1:0]   c_max;
  logic [TS_W-1:0]    p_last_ts;
  logic [TS_W-1:0]    p_period;
  logic [STOP_W-1:0]  p_idle;
  logic [RPM_W-1:0]   p_avg;
  logic [RPM_W-1:0]   p_latest;

  rpm_result_t rpm_expected[$];
  stim_row_t   directed[$];

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int mode_left = 0;
  int stall_run = 0;
  int rx_cnt = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic [TS_W-1:0] ts_now = '0;

  always #6 clk = ~clk;

  function automatic rpm_result_t tach_step(input logic [0:0] f, input logic [TS_W-1:0] ts);
    rpm_result_t r;
    logic [STOP_W-1:0] idle_prev;
    logic [DVS_W-1:0] dvs;
    logic [63:0] q;
    logic [31:0] blend;
    logic [RPM_W-1:0] raw_v;
    r.stop = 1'b0;
    if (f == FUNC_EDGE) begin
      if (ts > p_last_ts) p_period = ts - p_last_ts;
      p_last_ts = ts;
      p_idle = '0;
    end else begin
      if (p_period > 32'(c_debounce)) begin
        dvs = DVS_W'(p_period) * DVS_W'(c_poles);
        if (dvs == '0) begin
          raw_v = 16'hFFFF;
        end else begin
          q = 64'd960000000 / 64'(dvs);
          raw_v = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        end
        blend = 32'(p_avg) * 32'(c_alpha) + 32'(raw_v) * (32'd256 - 32'(c_alpha));
        p_latest = raw_v;
        p_avg = blend[23:8];
      end
      idle_prev = p_idle;
      if (p_idle != 8'hFF) p_idle = p_idle + 8'd1;
      if (idle_prev > c_stop) begin
        p_avg = '0;
        r.stop = 1'b1;
      end
      if (p_avg > c_max) p_avg = c_max;
    end
    r.filt = p_avg;
    r.raw = p_latest;
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = CFG_W'(data);
    return s;
  endfunction

  function automatic stim_row_t mk_item(input logic [0:0] f, input logic [TS_W-1:0] ts);
    stim_row_t s;
    s = '{default: '0};
    s.func = f;
    s.ts = ts;
    return s;
  endfunction

  function automatic stim_row_t mk_known(input logic [0:0] f, input logic [TS_W-1:0] ts,
                                         input int filt, input int raw, input bit stop);
    stim_row_t s;
    s = mk_item(f, ts);
    s.known = 1'b1;
    s.want.filt = RPM_W'(filt);
    s.want.raw = RPM_W'(raw);
    s.want.stop = stop;
    return s;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input logic [0:0] f, input logic [TS_W-1:0] ts,
                           input bit known = 1'b0, input rpm_result_t want = '0);
    rpm_result_t pred;
    int gap;
    in_ch.valid = 1'b1;
    in_ch.func = f;
    in_ch.timestamp_us = ts;
    do @(posedge clk); while (!in_ch.ready);
    pred = tach_step(f, ts);
    rpm_expected.push_back(known ? want : pred);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_ch.valid = 1'b0;
    while (rpm_expected.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DEBOUNCE: c_debounce = data[DEB_W-1:0];
      CFG_POLES:    c_poles = data[POLE_W-1:0];
      CFG_ALPHA:    c_alpha = data[ALPHA_W-1:0];
      CFG_STOP:     c_stop = data[STOP_W-1:0];
      CFG_MAX_RPM:  c_max = data[RPM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int p, input int n_items);
    int sent;
    int run;
    int k;
    int sel;
    logic [31:0] delta;
    logic [31:0] deb;
    sel = $urandom_range(0, 3);
    write_reg(CFG_DEBOUNCE,
              CFG_W'(sel == 0 ? 0 : sel == 1 ? 1000000 : $urandom_range(0, 200000)));
    sel = $urandom_range(0, 5);
    write_reg(CFG_POLES,
              CFG_W'(sel == 0 ? 0 : sel == 1 ? 1 : sel == 2 ? 64 : $urandom_range(1, 64)));
    sel = $urandom_range(0, 3);
    write_reg(CFG_ALPHA, CFG_W'(sel == 0 ? 0 : sel == 1 ? 255 : $urandom_range(0, 255)));
    sel = $urandom_range(0, 3);
    if (p == 4) write_reg(CFG_STOP, CFG_W'(254));
    else if (p == 5) write_reg(CFG_STOP, CFG_W'(255));
    else write_reg(CFG_STOP, CFG_W'(sel == 0 ? 0 : sel == 1 ? $urandom_range(0, 255)
                                           : $urandom_range(0, 8)));
    sel = $urandom_range(0, 6);
    write_reg(CFG_MAX_RPM,
              CFG_W'(sel == 0 ? 0 : sel < 3 ? 65535 : $urandom_range(0, 65535)));
    deb = 32'(c_debounce);
    sent = 0;
    // long tick run drives the idle counter into saturation
    if (p == 4 || p == 5) begin
      for (k = 0; k < 300; k++) send_item(FUNC_TICK, $urandom);
      sent += 300;
    end
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        send_item(1'($urandom_range(0, 1)), $urandom);
        sent++;
      end else begin
        if (sel < 60) delta = deb + $urandom_range(1, deb + 100000);
        else if (sel < 80) delta = $urandom_range(0, deb);
        else delta = 32'd0;
        if (sel < 88) ts_now = ts_now + delta;
        else if (sel < 95) ts_now = $urandom;
        send_item(FUNC_EDGE, ts_now);
        sent++;
        run = $urandom_range(0, 6);
        for (k = 0; k < run; k++) send_item(FUNC_TICK, $urandom);
        sent += run;
      end
    end
  endtask

  always @(negedge clk) begin
    logic rdy;
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_OPEN:    rdy = 1'b1;
      RX_COIN:    rdy = 1'($urandom_range(0, 1));
      RX_QUARTER: rdy = (rx_cnt % 4 == 0);
      default:    rdy = (stall_run >= 12) || ($urandom_range(0, 7) == 0);
    endcase
    stall_run = rdy ? 0 : stall_run + 1;
    rx_cnt++;
    out_ch.ready = rdy;
  end

  always @(posedge clk) begin
    rpm_result_t got;
    rpm_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.filt = out_ch.rpm_filtered;
      got.raw = out_ch.rpm_raw;
      got.stop = out_ch.stop_reset;
      if (rpm_expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: filt=%0d raw=%0d stop=%0b", got.filt, got.raw, got.stop);
      end else begin
        exp_r = rpm_expected.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: filt exp %0d got %0d, raw exp %0d got %0d, stop exp %0b got %0b",
                     exp_r.filt, got.filt, exp_r.raw, got.raw, exp_r.stop, got.stop);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_EDGE;
    in_ch.timestamp_us = '0;
    out_ch.ready = 1'b0;
    c_debounce = 20'd20000;
    c_poles = 7'd12;
    c_alpha = 8'd192;
    c_stop = 8'd50;
    c_max = 16'd2400;
    p_last_ts = '0;
    p_period = '0;
    p_idle = '0;
    p_avg = '0;
    p_latest = '0;

    // defaults after reset, equal and wrapped timestamps, short period
    directed.push_back(mk_known(FUNC_TICK, 32'h0, 0, 0, 1'b0));
    directed.push_back(mk_known(FUNC_EDGE, 32'h0, 0, 0, 1'b0));
    directed.push_back(mk_known(FUNC_EDGE, 32'd100000, 0, 0, 1'b0));
    directed.push_back(mk_item(FUNC_TICK, 32'hFFFFFFFF));
    directed.push_back(mk_item(FUNC_EDGE, 32'd110000));
    directed.push_back(mk_item(FUNC_TICK, 32'h0));
    directed.push_back(mk_item(FUNC_EDGE, 32'hFFFFFFFF));
    directed.push_back(mk_item(FUNC_TICK, 32'h5A5A5A5A));
    directed.push_back(mk_item(FUNC_EDGE, 32'd5));
    directed.push_back(mk_item(FUNC_TICK, 32'hA5A5A5A5));
    // zero poles with alpha 0: raw saturates and passes straight through
    directed.push_back(mk_cfg(CFG_ALPHA, 0));
    directed.push_back(mk_cfg(CFG_MAX_RPM, 65535));
    directed.push_back(mk_cfg(CFG_POLES, 0));
    directed.push_back(mk_cfg(CFG_DEBOUNCE, 0));
    directed.push_back(mk_item(FUNC_EDGE, 32'd6));
    directed.push_back(mk_known(FUNC_TICK, 32'h0, 65535, 65535, 1'b0));
    directed.push_back(mk_cfg(CFG_POLES, 64));
    directed.push_back(mk_known(FUNC_TICK, 32'h0, 65535, 65535, 1'b0));
    directed.push_back(mk_cfg(CFG_MAX_RPM, 0));
    directed.push_back(mk_known(FUNC_TICK, 32'h0, 0, 65535, 1'b0));
    // stop with zero limit, then heavy filter
    directed.push_back(mk_cfg(CFG_ALPHA, 255));
    directed.push_back(mk_cfg(CFG_MAX_RPM, 65535));
    directed.push_back(mk_cfg(CFG_DEBOUNCE, 1000000));
    directed.push_back(mk_cfg(CFG_STOP, 0));
    directed.push_back(mk_cfg(CFG_POLES, 1));
    directed.push_back(mk_item(FUNC_EDGE, 32'd2000006));
    directed.push_back(mk_item(FUNC_TICK, 32'h0));
    directed.push_back(mk_item(FUNC_TICK, 32'h0));
    directed.push_back(mk_cfg(CFG_STOP, 255));
    directed.push_back(mk_item(FUNC_TICK, 32'h0));
    directed.push_back(mk_item(FUNC_EDGE, 32'd1000000));
    directed.push_back(mk_item(FUNC_TICK, 32'h0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (i = 0; i < directed.size(); i++) begin
      if (directed[i].is_cfg)
        write_reg(directed[i].idx, directed[i].data);
      else
        send_item(directed[i].func, directed[i].ts, directed[i].known, directed[i].want);
    end
    ts_now = 32'd2000000;

    for (p = 0; p < 10; p++) run_phase(p, 160);

    in_ch.valid = 1'b0;
    while (rpm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
